// ===== hdl/assert_macros.svh =====
// Assertion helpers for the bucket rebalancer
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define ASSERT_NEVER(lbl, clk, rst, expr, msg) \
   `ASSERT_CLK(lbl, clk, rst, !(expr), msg)

`else

`define ASSERT_CLK(lbl, clk, rst, prop, msg)

`define ASSERT_NEVER(lbl, clk, rst, expr, msg)

`endif

`endif

// ===== hdl/ebr_pkg.sv =====
package ebr_pkg;

   localparam int CNT_W  = 9;
   localparam int IDX_W  = 8;
   localparam int MODE_W = 2;

   localparam logic [MODE_W-1:0] MODE_ADD  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_DEL  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_READ = 2'd2;

   localparam logic [CNT_W-1:0] ACTIVE_RESET = 9'd256;

   // table access from the sequencer, positions are zero-based
   typedef struct packed {
      logic             wr_en;
      logic [CNT_W-1:0] wr_pos;
      logic [CNT_W-1:0] wr_data;
      logic [CNT_W-1:0] rd_pos_a;
      logic [CNT_W-1:0] rd_pos_b;
   } tbl_req_type;

endpackage

// ===== hdl/ebr_req_if.sv =====
interface ebr_req_if;
   logic                      valid;
   logic                      ready;
   logic [ebr_pkg::MODE_W-1:0] mode;
   logic [ebr_pkg::IDX_W-1:0]  bucket_index;

   modport source (output valid, mode, bucket_index, input ready);
   modport sink   (input valid, mode, bucket_index, output ready);
endinterface

// ===== hdl/ebr_rsp_if.sv =====
interface ebr_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [ebr_pkg::CNT_W-1:0] hop_value;
   logic [ebr_pkg::CNT_W-1:0] hops_now;
   logic                      status;

   modport source (output valid, hop_value, hops_now, status, input ready);
   modport sink   (input valid, hop_value, hops_now, status, output ready);
endinterface

// ===== hdl/ecmp_bucket_rebalancer.sv =====
// channel | dir | handshake         | payload
// req_bus | in  | valid/ready       | mode, bucket_index
// rsp_bus | out | valid/ready       | hop_value, hops_now, status
// csr     | in  | csr_wr_en         | csr_wr_data = active_buckets
//
// One transaction at a time; n is the active bucket count after clamping.
// Add: one bucket walked per cycle.
// Delete: each rewritten bucket takes a read on the table read ports, a compare
// of the two and, on a match, a second read. Read: the index is reduced modulo n first.
// Reset starts a clearing pass over all MAX_BUCKETS entries; req_bus not ready meanwhile.
// A result held on rsp_bus does not stop the next transaction being taken.
module ecmp_bucket_rebalancer #(
   parameter int MAX_BUCKETS = 256
) (
   input  logic                      clock,
   input  logic                      reset,
   ebr_req_if.sink                   req_bus,
   ebr_rsp_if.source                 rsp_bus,
   input  logic                      csr_wr_en,
   input  logic [ebr_pkg::CNT_W-1:0] csr_wr_data
);

   localparam int CW = ebr_pkg::CNT_W;

   logic [CW-1:0]         active_ff, active_in;
   logic [CW-1:0]         n_active;
   ebr_pkg::tbl_req_type  tbl_req;
   logic [CW-1:0]         rd_a, rd_b;
   logic                  tbl_busy;

   assign active_in = csr_wr_en ? csr_wr_data : active_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= ebr_pkg::ACTIVE_RESET;
      end else begin
         active_ff <= active_in;
      end
   end

   always_comb begin
      if (active_ff == '0) begin
         n_active = CW'(1);
      end else if (int'(active_ff) > MAX_BUCKETS) begin
         n_active = CW'(MAX_BUCKETS);
      end else begin
         n_active = active_ff;
      end
   end

   ebr_table #(
      .MAX_BUCKETS (MAX_BUCKETS)
   ) u_table (
      .clock   (clock),
      .reset   (reset),
      .tbl_req (tbl_req),
      .rd_a    (rd_a),
      .rd_b    (rd_b),
      .busy    (tbl_busy)
   );

   ebr_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .n_active (n_active),
      .req      (req_bus),
      .rsp      (rsp_bus),
      .tbl_req  (tbl_req),
      .rd_a     (rd_a),
      .rd_b     (rd_b),
      .tbl_busy (tbl_busy)
   );

endmodule

// ===== hdl/ebr_table.sv =====
module ebr_table #(
   parameter int MAX_BUCKETS = 256
) (
   input  logic                      clock,
   input  logic                      reset,
   input  ebr_pkg::tbl_req_type      tbl_req,
   output logic [ebr_pkg::CNT_W-1:0] rd_a,
   output logic [ebr_pkg::CNT_W-1:0] rd_b,
   output logic                      busy
);

   localparam int AW = $clog2(MAX_BUCKETS);

   logic [ebr_pkg::CNT_W-1:0] mem [MAX_BUCKETS];
   logic [AW-1:0]             clr_ff, clr_in;
   logic                      busy_ff, busy_in;
   logic [ebr_pkg::CNT_W-1:0] rd_a_ff, rd_b_ff;

   always_comb begin
      clr_in  = clr_ff;
      busy_in = busy_ff;
      if (busy_ff) begin
         clr_in = clr_ff + AW'(1);
         if (clr_ff == AW'(MAX_BUCKETS - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff  <= '0;
         busy_ff <= 1'b1;
      end else begin
         clr_ff  <= clr_in;
         busy_ff <= busy_in;
      end
   end

   // clearing pass after reset takes the write port
   always_ff @(posedge clock) begin
      if (busy_ff) begin
         mem[clr_ff] <= '0;
      end else if (tbl_req.wr_en) begin
         mem[AW'(tbl_req.wr_pos)] <= tbl_req.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_a_ff <= mem[AW'(tbl_req.rd_pos_a)];
      rd_b_ff <= mem[AW'(tbl_req.rd_pos_b)];
   end

   assign rd_a = rd_a_ff;
   assign rd_b = rd_b_ff;
   assign busy = busy_ff;

endmodule

// ===== hdl/ebr_ctrl.sv =====
`include "assert_macros.svh"

module ebr_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [ebr_pkg::CNT_W-1:0] n_active,
   ebr_req_if.sink                   req,
   ebr_rsp_if.source                 rsp,
   output ebr_pkg::tbl_req_type      tbl_req,
   input  logic [ebr_pkg::CNT_W-1:0] rd_a,
   input  logic [ebr_pkg::CNT_W-1:0] rd_b,
   input  logic                      tbl_busy
);

   localparam int CW = ebr_pkg::CNT_W;
   localparam int IW = ebr_pkg::IDX_W;

   typedef enum logic [9:0] {
      ST_IDLE     = 10'b0000000001,
      ST_MOD      = 10'b0000000010,
      ST_RD_ISSUE = 10'b0000000100,
      ST_RD_DATA  = 10'b0000001000,
      ST_ADD      = 10'b0000010000,
      ST_CLR      = 10'b0000100000,
      ST_DEL      = 10'b0001000000,
      ST_DEL_CMP  = 10'b0010000000,
      ST_DEL_TWO  = 10'b0100000000,
      ST_DONE     = 10'b1000000000
   } state_type;

   state_type           state_ff, state_in;
   logic [CW-1:0]       pos_ff, pos_in;
   logic [CW-1:0]       phase_ff, phase_in;
   logic [CW-1:0]       period_ff, period_in;
   logic [CW-1:0]       hop_ff, hop_in;
   logic [CW-1:0]       rem_ff, rem_in;
   logic [IW-1:0]       idx_ff, idx_in;
   logic [2:0]          bit_ff, bit_in;
   logic [CW-1:0]       res_hop_ff, res_hop_in;
   logic                res_status_ff, res_status_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0]       rsp_hop_ff, rsp_hop_in;
   logic [CW-1:0]       rsp_hops_ff, rsp_hops_in;
   logic                rsp_status_ff, rsp_status_in;

   // shared compare-subtract
   logic [CW:0]         cs_a, cs_b, cs_diff;
   logic                cs_ge;

   logic                accept, hit, last, rsp_free;
   logic [CW-1:0]       prev_pos, back2_pos;

   assign accept   = req.valid && req.ready;
   assign hit      = (phase_ff == period_ff);
   assign last     = (pos_ff == n_active - CW'(1));
   assign rsp_free = !rsp_valid_ff || rsp.ready;
   assign prev_pos = pos_ff - CW'(1);
   assign back2_pos = (pos_ff < CW'(2)) ? (n_active - CW'(1)) : (pos_ff - CW'(2));

   always_comb begin
      if (state_ff == ST_MOD) begin
         cs_a = {rem_ff, idx_ff[IW-1]};
      end else begin
         cs_a = {1'b0, hop_ff};
      end
      cs_b    = {1'b0, n_active};
      cs_diff = cs_a - cs_b;
      cs_ge   = (cs_a >= cs_b);
   end

   always_comb begin
      state_in      = state_ff;
      pos_in        = pos_ff;
      phase_in      = phase_ff;
      period_in     = period_ff;
      hop_in        = hop_ff;
      rem_in        = rem_ff;
      idx_in        = idx_ff;
      bit_in        = bit_ff;
      res_hop_in    = res_hop_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_hop_in    = rsp_hop_ff;
      rsp_hops_in   = rsp_hops_ff;
      rsp_status_in = rsp_status_ff;

      tbl_req.wr_en    = 1'b0;
      tbl_req.wr_pos   = pos_ff;
      tbl_req.wr_data  = '0;
      tbl_req.rd_pos_a = prev_pos;
      tbl_req.rd_pos_b = pos_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               res_hop_in    = '0;
               res_status_in = 1'b0;
               pos_in        = '0;
               phase_in      = CW'(1);
               unique case (req.mode)
                  ebr_pkg::MODE_ADD: begin
                     if (cs_ge) begin
                        res_status_in = 1'b1;
                        state_in      = ST_DONE;
                     end else begin
                        period_in = hop_ff + CW'(1);
                        state_in  = ST_ADD;
                     end
                  end
                  ebr_pkg::MODE_DEL: begin
                     period_in = hop_ff;
                     if (hop_ff == '0) begin
                        res_status_in = 1'b1;
                        state_in      = ST_DONE;
                     end else if (hop_ff == CW'(1)) begin
                        state_in = ST_CLR;
                     end else begin
                        state_in = ST_DEL;
                     end
                  end
                  ebr_pkg::MODE_READ: begin
                     idx_in   = req.bucket_index;
                     rem_in   = '0;
                     bit_in   = 3'd7;
                     state_in = ST_MOD;
                  end
                  default: begin
                     res_status_in = 1'b1;
                     state_in      = ST_DONE;
                  end
               endcase
            end
         end
         ST_MOD: begin
            rem_in = cs_ge ? cs_diff[CW-1:0] : cs_a[CW-1:0];
            idx_in = {idx_ff[IW-2:0], 1'b0};
            bit_in = bit_ff - 3'd1;
            if (bit_ff == 3'd0) begin
               state_in = ST_RD_ISSUE;
            end
         end
         ST_RD_ISSUE: begin
            tbl_req.rd_pos_a = rem_ff;
            state_in         = ST_RD_DATA;
         end
         ST_RD_DATA: begin
            res_hop_in = rd_a;
            state_in   = ST_DONE;
         end
         ST_ADD: begin
            if (hit) begin
               tbl_req.wr_en   = 1'b1;
               tbl_req.wr_data = period_ff;
            end
            pos_in   = pos_ff + CW'(1);
            phase_in = hit ? CW'(1) : (phase_ff + CW'(1));
            if (last) begin
               hop_in   = period_ff;
               state_in = ST_DONE;
            end
         end
         ST_CLR: begin
            tbl_req.wr_en = 1'b1;
            pos_in        = pos_ff + CW'(1);
            if (last) begin
               hop_in   = hop_ff - CW'(1);
               state_in = ST_DONE;
            end
         end
         ST_DEL: begin
            if (hit) begin
               state_in = ST_DEL_CMP;
            end else begin
               pos_in   = pos_ff + CW'(1);
               phase_in = phase_ff + CW'(1);
               if (last) begin
                  hop_in   = hop_ff - CW'(1);
                  state_in = ST_DONE;
               end
            end
         end
         ST_DEL_CMP: begin
            if (rd_a == rd_b) begin
               tbl_req.rd_pos_a = back2_pos;
               state_in         = ST_DEL_TWO;
            end else begin
               tbl_req.wr_en   = 1'b1;
               tbl_req.wr_data = rd_a;
               pos_in          = pos_ff + CW'(1);
               phase_in        = CW'(1);
               state_in        = last ? ST_DONE : ST_DEL;
               if (last) begin
                  hop_in = hop_ff - CW'(1);
               end
            end
         end
         ST_DEL_TWO: begin
            tbl_req.wr_en   = 1'b1;
            tbl_req.wr_data = rd_a;
            pos_in          = pos_ff + CW'(1);
            phase_in        = CW'(1);
            state_in        = last ? ST_DONE : ST_DEL;
            if (last) begin
               hop_in = hop_ff - CW'(1);
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_hop_in    = res_hop_ff;
               rsp_hops_in   = hop_ff;
               rsp_status_in = res_status_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         hop_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hop_ff       <= hop_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff        <= pos_in;
      phase_ff      <= phase_in;
      period_ff     <= period_in;
      rem_ff        <= rem_in;
      idx_ff        <= idx_in;
      bit_ff        <= bit_in;
      res_hop_ff    <= res_hop_in;
      res_status_ff <= res_status_in;
      rsp_hop_ff    <= rsp_hop_in;
      rsp_hops_ff   <= rsp_hops_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign req.ready     = (state_ff == ST_IDLE) && !tbl_busy;
   assign rsp.valid     = rsp_valid_ff;
   assign rsp.hop_value = rsp_hop_ff;
   assign rsp.hops_now  = rsp_hops_ff;
   assign rsp.status    = rsp_status_ff;

   `ASSERT_CLK(a_busy_after_accept, clock, reset, accept |=> !req.ready, "ready after accept")
   `ASSERT_CLK(a_wr_in_walk, clock, reset, tbl_req.wr_en |-> (state_ff == ST_ADD || state_ff == ST_CLR || state_ff == ST_DEL_CMP || state_ff == ST_DEL_TWO), "table write outside walk")
   `ASSERT_CLK(a_pos_in_range, clock, reset, (state_ff == ST_ADD || state_ff == ST_CLR || state_ff == ST_DEL || state_ff == ST_DEL_CMP || state_ff == ST_DEL_TWO) |-> (pos_ff < n_active), "walk position beyond active buckets")
   `ASSERT_CLK(a_rsp_load, clock, reset, (state_ff == ST_DONE && rsp_free) |=> (rsp_valid_ff && state_ff == ST_IDLE), "result not loaded")
   `ASSERT_NEVER(a_no_accept_clearing, clock, reset, req.ready && tbl_busy, "ready during clearing pass")

endmodule
